FILE: hw/rtl/bsm_pkg.sv
`timescale 1ns / 1ps

package bsm_pkg;

  // map geometry
  localparam int FLOOR_SLOTS = 64;
  localparam int MAX_MODULES = 64;
  localparam int MIN_FLOOR   = -32;
  localparam int LAYER_COUNT = 16;

  // field widths
  localparam int ACTION_W = 3;
  localparam int FLOOR_W  = 8;
  localparam int MODREQ_W = 7;
  localparam int LAYER_W  = 4;
  localparam int DIR_W    = 2;
  localparam int SMOD_W   = 6;
  localparam int MFLOOR_W = 6;

  localparam int SLOT_W = $clog2(FLOOR_SLOTS);
  localparam int MOD_W  = $clog2(MAX_MODULES);
  // signed slot arithmetic, wide enough for any floor minus any minimum
  localparam int SIDX_W = 10;

  // search tree geometry
  localparam int GRP_SIZE  = 8;
  localparam int GRP_IDX_W = 3;
  localparam int GRP_NUM   = (FLOOR_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_W     = GRP_NUM * GRP_SIZE;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ASSIGN    = 3'd0,
    ACT_CLEAR     = 3'd1,
    ACT_SET_LAYER = 3'd2,
    ACT_CLR_LAYER = 3'd3,
    ACT_QUERY     = 3'd4,
    ACT_NEXT      = 3'd5
  } action_e;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [LAYER_W-1:0] layer;
  } mod_entry_t;

  typedef struct packed {
    logic                     up;
    logic signed [SIDX_W-1:0] start;
  } srch_req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } srch_rsp_t;

endpackage

FILE: hw/rtl/bsm_ram.sv
`timescale 1ns / 1ps

module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/bsm_search.sv
`timescale 1ns / 1ps

module bsm_search
  import bsm_pkg::*;
(
  input  logic                   clk_i,
  input  logic [FLOOR_SLOTS-1:0] used_i,
  input  srch_req_t              req_i,
  output srch_rsp_t              rsp_o
);

  logic [PAD_W-1:0]     used_pad;
  logic [PAD_W-1:0]     cand;
  logic [GRP_NUM-1:0]   grp_any_d, grp_any_q;
  logic [GRP_IDX_W-1:0] grp_idx_d [GRP_NUM];
  logic [GRP_IDX_W-1:0] grp_idx_q [GRP_NUM];
  logic                 up_q;
  srch_rsp_t            rsp_d;

  assign used_pad = PAD_W'(used_i);

  // candidate slots strictly above or below the start
  always_comb begin
    logic signed [SIDX_W-1:0] ii;
    ii = '0;
    for (int i = 0; i < PAD_W; i++) begin
      ii = SIDX_W'(i);
      cand[i] = used_pad[i] && (req_i.up ? (ii > req_i.start) : (ii < req_i.start));
    end
  end

  // stage one: nearest candidate inside each group
  always_comb begin
    for (int g = 0; g < GRP_NUM; g++) begin
      grp_any_d[g] = |cand[g*GRP_SIZE +: GRP_SIZE];
      grp_idx_d[g] = '0;
      if (req_i.up) begin
        for (int k = GRP_SIZE - 1; k >= 0; k--) begin
          if (cand[g*GRP_SIZE + k]) grp_idx_d[g] = GRP_IDX_W'(k);
        end
      end else begin
        for (int k = 0; k < GRP_SIZE; k++) begin
          if (cand[g*GRP_SIZE + k]) grp_idx_d[g] = GRP_IDX_W'(k);
        end
      end
    end
  end

  // stage two: nearest group
  always_comb begin
    rsp_d = '0;
    if (up_q) begin
      for (int g = GRP_NUM - 1; g >= 0; g--) begin
        if (grp_any_q[g]) begin
          rsp_d.found = 1'b1;
          rsp_d.slot  = SLOT_W'(g * GRP_SIZE + int'(grp_idx_q[g]));
        end
      end
    end else begin
      for (int g = 0; g < GRP_NUM; g++) begin
        if (grp_any_q[g]) begin
          rsp_d.found = 1'b1;
          rsp_d.slot  = SLOT_W'(g * GRP_SIZE + int'(grp_idx_q[g]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    grp_idx_q <= grp_idx_d;
    up_q      <= req_i.up;
    rsp_o     <= rsp_d;
  end

endmodule

FILE: hw/rtl/bidirectional_slot_map_with_search.sv
`timescale 1ns / 1ps

// bidirectional slot map with nearest-occupied search
// input channel: in_valid_i / in_stall_o, one command beat (action, floor, module id,
//   layer, direction); a beat is taken on a rising edge with valid high and stall low
// output channel: out_valid_o / out_stall_i, one result beat per command holding the
//   lookups of the state after the command's action, taken at its floor and module id
// a command passes the read, modify and finish states; its result is registered as it
//   leaves finish, and the next command is taken only after that (accept, read both
//   tables, modify and write back, final lookup); the module table read port sets this,
//   as the layer of the module at the floor is only known after the slot table is updated
// in_stall_o is high while a command is in flight; the next command is taken while
//   the previous result still waits in the output register
// when the receiver stalls, the result beat holds and the block finishes at most one
//   more command into its final state, waiting there until the output register frees
// reset clears all occupancy, floor-held and resident flags at once, so the block
//   accepts a command in the first cycle after reset; table contents need no clearing
module bidirectional_slot_map_with_search
  import bsm_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ACTION_W-1:0]        in_action_i,
  input  logic signed [FLOOR_W-1:0]  in_floor_i,
  input  logic [MODREQ_W-1:0]        in_module_req_i,
  input  logic [LAYER_W-1:0]         in_layer_i,
  input  logic signed [DIR_W-1:0]    in_direction_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [SMOD_W-1:0]          out_slot_module_o,
  output logic                       out_slot_module_valid_o,
  output logic signed [MFLOOR_W-1:0] out_module_floor_o,
  output logic                       out_module_floor_valid_o,
  output logic [LAYER_W-1:0]         out_module_layer_o,
  output logic                       out_module_layer_valid_o,
  output logic [LAYER_W-1:0]         out_floor_layer_o,
  output logic                       out_floor_layer_valid_o,
  output logic signed [FLOOR_W-1:0]  out_next_floor_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MODIFY,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  // command registers
  action_e                   action_q;
  logic signed [FLOOR_W-1:0] floor_q;
  logic [MODREQ_W-1:0]       modreq_q;
  logic [LAYER_W-1:0]        layer_q;
  logic [DIR_W-1:0]          dir_q;

  // per-entry flags, the table contents count only where these are set
  logic [FLOOR_SLOTS-1:0] used_q, used_d;     // slot holds a module
  logic [MAX_MODULES-1:0] has_q, has_d;       // module holds a slot
  logic [MAX_MODULES-1:0] res_q, res_d;       // module has a layer

  // decoded command
  logic signed [SIDX_W-1:0] slot_s;
  logic                     slot_ok;
  logic [SLOT_W-1:0]        sidx;
  logic                     mod_ok;
  logic [MOD_W-1:0]         midx;
  logic                     assign_do, clear_do, setl_do, clrl_do;

  // table ports
  logic [MOD_W-1:0] slot_rdata;
  logic             slot_we;
  mod_entry_t       mod_rdata;
  logic             mod_we;
  logic [MOD_W-1:0] mod_raddr;

  // read-modify-write
  logic             h_used;
  logic             old_has;
  logic [MOD_W-1:0] post_slot_mod_c, post_slot_mod_q;
  mod_entry_t       post_mod_c, post_mod_q;
  logic             x_eq_m_q;

  // search
  srch_req_t srch_req;
  srch_rsp_t srch_rsp;

  // result
  logic                       in_accept, out_load, out_valid_q;
  logic                       smv_c, mfv_c, mlv_c, flv_c;
  logic signed [SIDX_W-1:0]   mf_full, nf_full;
  logic [SMOD_W-1:0]          sm_q;
  logic                       smv_q, mfv_q, mlv_q, flv_q;
  logic signed [MFLOOR_W-1:0] mf_q;
  logic [LAYER_W-1:0]         ml_q, fl_q;
  logic signed [FLOOR_W-1:0]  nf_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  // floor number to slot index, out-of-range floors are flagged
  assign slot_s  = SIDX_W'(floor_q) - SIDX_W'(MIN_FLOOR);
  assign slot_ok = (slot_s >= 0) && (slot_s < $signed(SIDX_W'(FLOOR_SLOTS)));
  assign sidx    = slot_s[SLOT_W-1:0];
  assign mod_ok  = {1'b0, modreq_q} < (MODREQ_W + 1)'(MAX_MODULES);
  assign midx    = modreq_q[MOD_W-1:0];

  assign assign_do = (action_q == ACT_ASSIGN) && slot_ok && mod_ok;
  assign clear_do  = (action_q == ACT_CLEAR) && slot_ok;
  assign setl_do   = (action_q == ACT_SET_LAYER) && mod_ok
                     && ({1'b0, layer_q} < (LAYER_W + 1)'(LAYER_COUNT));
  assign clrl_do   = (action_q == ACT_CLR_LAYER) && mod_ok;

  // slot -> module table
  assign slot_we = (state_q == ST_MODIFY) && assign_do;

  bsm_ram #(
    .WIDTH (MOD_W),
    .DEPTH (FLOOR_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (sidx),
    .wdata_i (midx),
    .raddr_i (sidx),
    .rdata_o (slot_rdata)
  );

  // module -> {slot, layer} table, second read picks up the module at the floor
  assign mod_we = (state_q == ST_MODIFY) && (assign_do || setl_do);

  always_comb begin
    case (state_q)
      ST_READ:   mod_raddr = midx;
      ST_MODIFY: mod_raddr = post_slot_mod_c;
      default:   mod_raddr = post_slot_mod_q;
    endcase
  end

  bsm_ram #(
    .WIDTH ($bits(mod_entry_t)),
    .DEPTH (MAX_MODULES)
  ) u_mod_ram (
    .clk_i   (clk_i),
    .we_i    (mod_we),
    .waddr_i (midx),
    .wdata_i (post_mod_c),
    .raddr_i (mod_raddr),
    .rdata_o (mod_rdata)
  );

  // old holder of the slot and old slot of the module
  assign h_used  = used_q[sidx];
  // the module keeps its old slot only if it was not the old holder itself
  assign old_has = has_q[midx] && !(h_used && (slot_rdata == midx));

  assign post_slot_mod_c = assign_do ? midx : slot_rdata;

  always_comb begin
    post_mod_c = mod_rdata;
    if (assign_do) post_mod_c.slot = sidx;
    if (setl_do) post_mod_c.layer = layer_q;
  end

  // flag updates, applied at the end of the modify cycle
  always_comb begin
    used_d = used_q;
    has_d  = has_q;
    res_d  = res_q;
    if (state_q == ST_MODIFY) begin
      if (assign_do) begin
        if (h_used) has_d[slot_rdata] = 1'b0;
        if (old_has) used_d[mod_rdata.slot] = 1'b0;
        used_d[sidx] = 1'b1;
        has_d[midx]  = 1'b1;
      end
      if (clear_do) begin
        if (h_used) has_d[slot_rdata] = 1'b0;
        used_d[sidx] = 1'b0;
      end
      if (setl_do) res_d[midx] = 1'b1;
      if (clrl_do) res_d[midx] = 1'b0;
    end
  end

  // nearest occupied slot, two registered levels over the occupancy flags
  assign srch_req.up    = (dir_q == DIR_UP);
  assign srch_req.start = slot_s;

  bsm_search u_search (
    .clk_i  (clk_i),
    .used_i (used_q),
    .req_i  (srch_req),
    .rsp_o  (srch_rsp)
  );

  // lookups on the state after the action; unless stalled, the search sees the flags before it
  assign smv_c   = slot_ok && used_q[sidx];
  assign mfv_c   = mod_ok && has_q[midx];
  assign mlv_c   = mod_ok && res_q[midx];
  assign flv_c   = smv_c && res_q[post_slot_mod_q];
  assign mf_full = SIDX_W'(post_mod_q.slot) + SIDX_W'(MIN_FLOOR);
  assign nf_full = SIDX_W'(srch_rsp.slot) + SIDX_W'(MIN_FLOOR);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_READ;
      ST_READ:   state_d = ST_MODIFY;
      ST_MODIFY: state_d = ST_FINISH;
      ST_FINISH: if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control state and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      has_q       <= '0;
      res_q       <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      has_q   <= has_d;
      res_q   <= res_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q <= action_e'(in_action_i);
      floor_q  <= in_floor_i;
      modreq_q <= in_module_req_i;
      layer_q  <= in_layer_i;
      dir_q    <= in_direction_i;
    end
    if (state_q == ST_MODIFY) begin
      post_slot_mod_q <= post_slot_mod_c;
      post_mod_q      <= post_mod_c;
      x_eq_m_q        <= (post_slot_mod_c == midx);
    end
    if (out_load) begin
      smv_q <= smv_c;
      sm_q  <= smv_c ? SMOD_W'(post_slot_mod_q) : '0;
      mfv_q <= mfv_c;
      mf_q  <= mfv_c ? mf_full[MFLOOR_W-1:0] : '0;
      mlv_q <= mlv_c;
      ml_q  <= mlv_c ? post_mod_q.layer : '0;
      flv_q <= flv_c;
      // the module at the floor may be the one just rewritten
      if (!flv_c) begin
        fl_q <= '0;
      end else if (x_eq_m_q) begin
        fl_q <= post_mod_q.layer;
      end else begin
        fl_q <= mod_rdata.layer;
      end
      if ((action_q == ACT_NEXT) && (dir_q != DIR_NONE) && srch_rsp.found) begin
        nf_q <= nf_full[FLOOR_W-1:0];
      end else begin
        nf_q <= floor_q;
      end
    end
  end

  assign out_valid_o              = out_valid_q;
  assign out_slot_module_o        = sm_q;
  assign out_slot_module_valid_o  = smv_q;
  assign out_module_floor_o       = mf_q;
  assign out_module_floor_valid_o = mfv_q;
  assign out_module_layer_o       = ml_q;
  assign out_module_layer_valid_o = mlv_q;
  assign out_floor_layer_o        = fl_q;
  assign out_floor_layer_valid_o  = flv_q;
  assign out_next_floor_o         = nf_q;

endmodule

FILE: hw/rtl/bsm_checker.sv
`timescale 1ns / 1ps

module bsm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [2:0]        in_action_i,
  input logic signed [7:0] in_floor_i,
  input logic [6:0]        in_module_req_i,
  input logic [3:0]        in_layer_i,
  input logic signed [1:0] in_direction_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [5:0]        out_slot_module_o,
  input logic              out_slot_module_valid_o,
  input logic signed [5:0] out_module_floor_o,
  input logic              out_module_floor_valid_o,
  input logic [3:0]        out_module_layer_o,
  input logic              out_module_layer_valid_o,
  input logic [3:0]        out_floor_layer_o,
  input logic              out_floor_layer_valid_o,
  input logic signed [7:0] out_next_floor_o
);

  // stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_next_floor_o) && $stable(out_slot_module_o))
    else $error("stalled result beat changed");

  // a command keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second command taken while one is in flight");

  // no mapping at the floor means no module and no layer there
  a_floor_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_slot_module_valid_o |->
      out_slot_module_o == 6'd0 && !out_floor_layer_valid_o && out_floor_layer_o == 4'd0)
    else $error("empty floor reports a module or layer");

  a_module_unplaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_module_floor_valid_o |-> out_module_floor_o == 6'sd0)
    else $error("unplaced module reports a floor");

endmodule

bind bidirectional_slot_map_with_search bsm_checker u_bsm_checker (.*);
